>>> hdl/tile_map_pixel_generator_defines.svh
// assertion macros shared by the tile map pixel generator modules
// each macro expects signals named clk and rst_n in the using module
`ifndef TILE_MAP_PIXEL_GENERATOR_DEFINES_SVH
`define TILE_MAP_PIXEL_GENERATOR_DEFINES_SVH

// same-cycle implication
`define TMPG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TMPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/tmpg_pkg.sv
`default_nettype none

package tmpg_pkg;

  // map and store geometry
  localparam int MAP_COLUMNS    = 15;
  localparam int MAP_ROWS       = 20;
  localparam int TILE_COUNT     = 16;
  localparam int TILE_SIDE      = 16;
  localparam int WORDS_PER_TILE = 32;
  localparam int WORDS_PER_LINE = 2;
  localparam int PALETTE_SIZE   = 16;
  localparam int MAP_SIZE       = MAP_COLUMNS * MAP_ROWS;
  localparam int PATTERN_SIZE   = TILE_COUNT * WORDS_PER_TILE;

  // store address widths
  localparam int MAP_AW = (MAP_SIZE > 1) ? $clog2(MAP_SIZE) : 1;
  localparam int PAT_AW = (PATTERN_SIZE > 1) ? $clog2(PATTERN_SIZE) : 1;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    CMD_MAP_WR = 2'd0,
    CMD_PAT_WR = 2'd1,
    CMD_PAL_WR = 2'd2,
    CMD_RENDER = 2'd3
  } cmd_t;

  // one queued transaction for the back end
  typedef struct packed {
    cmd_t        cmd;
    logic [8:0]  addr;
    logic [31:0] data;
    logic [3:0]  tile;
    logic [3:0]  line;
  } q_item_t;

  // queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

>>> hdl/tmpg_front.sv
`default_nettype none

`include "tile_map_pixel_generator_defines.svh"

module tmpg_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire logic [1:0]          in_command,
  input  wire logic [8:0]          in_address,
  input  wire logic [31:0]         in_write_data,
  input  wire logic [8:0]          in_screen_row,
  input  wire logic [3:0]          in_tile_column,
  input  wire tmpg_pkg::q_status_t q_status,
  output logic                     q_push,
  output tmpg_pkg::q_item_t        q_item
);

  // tile map memory with clearing pass after reset
  logic [3:0]                 map_mem [tmpg_pkg::MAP_SIZE];
  logic [3:0]                 map_rd_r;
  logic                       clearing_r, clearing_nxt;
  logic [tmpg_pkg::MAP_AW-1:0] clr_idx_r, clr_idx_nxt;

  // second stage holding the transaction while the map read completes
  logic              s1_valid_r, s1_valid_nxt;
  tmpg_pkg::q_item_t s1_item_r, s1_item_nxt;
  logic              s1_in_map_r;
  logic              s1_wants_push;
  logic              s1_stall;

  logic                        accept;
  tmpg_pkg::cmd_t              cmd;
  logic [4:0]                  tile_row;
  logic                        in_map_c;
  logic [tmpg_pkg::MAP_AW-1:0] map_idx;
  logic                        map_we;
  logic [tmpg_pkg::MAP_AW-1:0] map_waddr;
  logic [3:0]                  map_wdata;
  logic                        map_re;

  // input handshake
  assign cmd           = tmpg_pkg::cmd_t'(in_command);
  assign s1_wants_push = s1_valid_r && (s1_item_r.cmd != tmpg_pkg::CMD_MAP_WR);
  assign s1_stall      = s1_wants_push && q_status.full;
  assign in_full       = clearing_r || s1_stall;
  assign accept        = in_push && !in_full;

  // map index of the rendered tile
  assign tile_row = in_screen_row[8:4];
  assign in_map_c = (int'(tile_row) < tmpg_pkg::MAP_ROWS) &&
                    (int'(in_tile_column) < tmpg_pkg::MAP_COLUMNS);
  assign map_idx  = in_map_c ?
                    tmpg_pkg::MAP_AW'(int'(tile_row) * tmpg_pkg::MAP_COLUMNS +
                                      int'(in_tile_column)) : '0;

  // map write port: clearing pass or a map write transaction
  always_comb begin
    map_we    = 1'b0;
    map_waddr = clr_idx_r;
    map_wdata = 4'd0;
    if (clearing_r) begin
      map_we = 1'b1;
    end else if (accept && cmd == tmpg_pkg::CMD_MAP_WR &&
                 int'(in_address) < tmpg_pkg::MAP_SIZE) begin
      map_we    = 1'b1;
      map_waddr = tmpg_pkg::MAP_AW'(in_address);
      map_wdata = in_write_data[3:0];
    end
  end

  assign map_re = accept && cmd == tmpg_pkg::CMD_RENDER;

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    if (map_re) begin
      map_rd_r    <= map_mem[map_idx];
      s1_in_map_r <= in_map_c;
    end
  end

  // clearing pass sequencing
  always_comb begin
    clearing_nxt = clearing_r;
    clr_idx_nxt  = clr_idx_r;
    if (clearing_r) begin
      if (clr_idx_r == tmpg_pkg::MAP_AW'(tmpg_pkg::MAP_SIZE - 1)) begin
        clearing_nxt = 1'b0;
      end else begin
        clr_idx_nxt = clr_idx_r + 1'b1;
      end
    end
  end

  // second stage next state
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_item_nxt  = s1_item_r;
    if (accept) begin
      s1_valid_nxt     = 1'b1;
      s1_item_nxt.cmd  = cmd;
      s1_item_nxt.addr = in_address;
      s1_item_nxt.data = in_write_data;
      s1_item_nxt.tile = 4'd0;
      s1_item_nxt.line = in_screen_row[3:0];
    end else if (!s1_stall) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_idx_r  <= clr_idx_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
    s1_item_r <= s1_item_nxt;
  end

  // hand off to the queue, tile taken as zero outside the map
  assign q_push = s1_wants_push && !q_status.full;
  always_comb begin
    q_item      = s1_item_r;
    q_item.tile = s1_in_map_r ? map_rd_r : 4'd0;
  end

  `TMPG_ASSERT_NOW(a_no_accept_while_clearing, clearing_r, !accept,
                   "transaction accepted during map clearing pass")
  `TMPG_ASSERT_NEXT(a_stalled_stage_holds, s1_stall, s1_valid_r && $stable(s1_item_r),
                    "stalled front stage lost its transaction")

endmodule

`default_nettype wire

>>> hdl/tmpg_queue.sv
`default_nettype none

module tmpg_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire tmpg_pkg::q_item_t   push_item,
  input  wire logic                pop,
  output tmpg_pkg::q_item_t        head_item,
  output tmpg_pkg::q_status_t      status
);

  tmpg_pkg::q_item_t           slots_r [tmpg_pkg::QUEUE_DEPTH];
  logic [tmpg_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [tmpg_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [tmpg_pkg::QPTR_W:0]   cnt_r, cnt_nxt;
  logic                        do_push, do_pop;

  assign status.full  = (cnt_r == (tmpg_pkg::QPTR_W + 1)'(tmpg_pkg::QUEUE_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_item    = slots_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

>>> hdl/tmpg_back.sv
`default_nettype none

`include "tile_map_pixel_generator_defines.svh"

module tmpg_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                invert,
  input  wire tmpg_pkg::q_item_t   head_item,
  input  wire tmpg_pkg::q_status_t q_status,
  output logic                     q_pop,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output logic [15:0]              out_pixel_colour,
  output logic                     out_last_pixel
);

  // pattern memory, two read ports for the two words of a tile line
  logic [31:0] pat_mem [tmpg_pkg::PATTERN_SIZE];
  logic [31:0] w0_r, w1_r;
  logic        l_valid_r, l_valid_nxt;
  logic        l_zero_r;

  // palette registers
  logic [15:0] palette_r [tmpg_pkg::PALETTE_SIZE];

  // pixel shifter
  logic        b_valid_r, b_valid_nxt;
  logic [63:0] line_r, line_nxt;
  logic [3:0]  b_cnt_r, b_cnt_nxt;

  // output queue
  logic [16:0] of_mem_r [2];
  logic        of_wr_r, of_rd_r;
  logic [1:0]  of_cnt_r, of_cnt_nxt;
  logic        of_space, of_pop;

  logic                        pop_ok;
  logic                        render_issue;
  logic                        pat_we, pal_we;
  logic                        tile_ok;
  logic [tmpg_pkg::PAT_AW-1:0] rd_addr0, rd_addr1;
  logic                        emit, last, l_take;
  logic [15:0]                 colour;

  // pixel emission and line buffer handoff
  assign of_space = (of_cnt_r != 2'd2) || out_pop;
  assign emit     = b_valid_r && of_space;
  assign last     = (b_cnt_r == 4'(tmpg_pkg::TILE_SIDE - 1));
  assign l_take   = l_valid_r && (!b_valid_r || (emit && last));

  // decide whether the head transaction can be carried out now
  always_comb begin
    pop_ok = 1'b1;
    unique case (head_item.cmd)
      tmpg_pkg::CMD_PAL_WR: pop_ok = !l_valid_r && !b_valid_r;
      tmpg_pkg::CMD_RENDER: pop_ok = !l_valid_r || l_take;
      default:              pop_ok = 1'b1;
    endcase
  end

  assign q_pop        = !q_status.empty && pop_ok;
  assign render_issue = q_pop && head_item.cmd == tmpg_pkg::CMD_RENDER;
  assign pat_we       = q_pop && head_item.cmd == tmpg_pkg::CMD_PAT_WR &&
                        int'(head_item.addr) < tmpg_pkg::PATTERN_SIZE;
  assign pal_we       = q_pop && head_item.cmd == tmpg_pkg::CMD_PAL_WR &&
                        int'(head_item.addr) < tmpg_pkg::PALETTE_SIZE;
  assign tile_ok      = int'(head_item.tile) < tmpg_pkg::TILE_COUNT;

  // word addresses of the rendered tile line
  assign rd_addr0 = tile_ok ?
                    tmpg_pkg::PAT_AW'(int'(head_item.tile) * tmpg_pkg::WORDS_PER_TILE +
                                      int'(head_item.line) * tmpg_pkg::WORDS_PER_LINE) : '0;
  assign rd_addr1 = rd_addr0 + 1'b1;

  // pattern and palette stores
  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_mem[tmpg_pkg::PAT_AW'(head_item.addr)] <= head_item.data;
    end
    if (render_issue) begin
      w0_r     <= pat_mem[rd_addr0];
      w1_r     <= pat_mem[rd_addr1];
      l_zero_r <= !tile_ok;
    end
    if (pal_we) begin
      palette_r[head_item.addr[3:0]] <= head_item.data[15:0];
    end
  end

  // line buffer and shifter next state
  always_comb begin
    l_valid_nxt = l_valid_r;
    if (render_issue) begin
      l_valid_nxt = 1'b1;
    end else if (l_take) begin
      l_valid_nxt = 1'b0;
    end

    b_valid_nxt = b_valid_r;
    line_nxt    = line_r;
    b_cnt_nxt   = b_cnt_r;
    if (l_take) begin
      b_valid_nxt = 1'b1;
      line_nxt    = l_zero_r ? 64'd0 : {w0_r, w1_r};
      b_cnt_nxt   = 4'd0;
    end else if (emit) begin
      line_nxt  = {line_r[59:0], 4'd0};
      b_cnt_nxt = b_cnt_r + 4'd1;
      if (last) begin
        b_valid_nxt = 1'b0;
      end
    end
  end

  // palette lookup, most significant nibble first
  assign colour = palette_r[line_r[63:60]] ^ {16{invert}};

  // output queue control
  assign out_empty = (of_cnt_r == 2'd0);
  assign of_pop    = out_pop && !out_empty;

  always_comb begin
    of_cnt_nxt = of_cnt_r;
    if (emit && !of_pop) begin
      of_cnt_nxt = of_cnt_r + 2'd1;
    end else if (of_pop && !emit) begin
      of_cnt_nxt = of_cnt_r - 2'd1;
    end
  end

  assign out_pixel_colour = of_mem_r[of_rd_r][16:1];
  assign out_last_pixel   = of_mem_r[of_rd_r][0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      b_cnt_r   <= 4'd0;
      of_wr_r   <= 1'b0;
      of_rd_r   <= 1'b0;
      of_cnt_r  <= 2'd0;
    end else begin
      l_valid_r <= l_valid_nxt;
      b_valid_r <= b_valid_nxt;
      b_cnt_r   <= b_cnt_nxt;
      of_cnt_r  <= of_cnt_nxt;
      if (emit) begin
        of_wr_r <= ~of_wr_r;
      end
      if (of_pop) begin
        of_rd_r <= ~of_rd_r;
      end
    end
    line_r <= line_nxt;
    if (emit) begin
      of_mem_r[of_wr_r] <= {colour, last};
    end
  end

  `TMPG_ASSERT_NOW(a_palette_write_after_drain,
                   q_pop && head_item.cmd == tmpg_pkg::CMD_PAL_WR,
                   !l_valid_r && !b_valid_r,
                   "palette written while render pixels pending")
  `TMPG_ASSERT_NOW(a_out_queue_no_overflow, of_cnt_r == 2'd2 && !out_pop, !emit,
                   "pixel emitted into full output queue")
  `TMPG_ASSERT_NEXT(a_line_load_restarts, l_take, b_valid_r && b_cnt_r == 4'd0,
                    "line load did not restart the pixel count")
  `TMPG_ASSERT_NEXT(a_line_done, emit && last && !l_take, !b_valid_r,
                    "shifter still busy after its last pixel")

endmodule

`default_nettype wire

>>> hdl/tile_map_pixel_generator.sv
// channel  ports                                   transaction when
// in       in_push in_full in_command ...          in_push && !in_full
// out      out_empty out_pop out_pixel_colour ...  out_pop && !out_empty
// cfg      cfg_write_enable cfg_write_data         cfg_write_enable
//
// a render gives 16 pixels at one per cycle while the output queue has room,
// set by the pixel shifter; the next render can load while one is shifting out
// a palette write waits in the queue until pending render pixels have left
// the shifter; pattern lines are read through a two-port pattern memory
// after reset a clearing pass zeroes all MAP_SIZE (300) entries of the tile map
// with in_full high; cfg writes are taken throughout
// a stalled out side fills the output and front/back queues, then in_full rises
`default_nettype none

module tile_map_pixel_generator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_command,
  input  wire logic [8:0]  in_address,
  input  wire logic [31:0] in_write_data,
  input  wire logic [8:0]  in_screen_row,
  input  wire logic [3:0]  in_tile_column,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [15:0]      out_pixel_colour,
  output logic             out_last_pixel,
  input  wire logic        cfg_write_enable,
  input  wire logic        cfg_write_data
);

  logic                invert_r, invert_nxt;
  logic                q_push, q_pop;
  tmpg_pkg::q_item_t   q_push_item, q_head_item;
  tmpg_pkg::q_status_t q_status;

  // configuration register
  assign invert_nxt = cfg_write_enable ? cfg_write_data : invert_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r <= 1'b0;
    end else begin
      invert_r <= invert_nxt;
    end
  end

  // front end: accept, map access, classify
  tmpg_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_command     (in_command),
    .in_address     (in_address),
    .in_write_data  (in_write_data),
    .in_screen_row  (in_screen_row),
    .in_tile_column (in_tile_column),
    .q_status       (q_status),
    .q_push         (q_push),
    .q_item         (q_push_item)
  );

  // queue between front and back
  tmpg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .pop       (q_pop),
    .head_item (q_head_item),
    .status    (q_status)
  );

  // back end: pattern and palette stores, pixel output
  tmpg_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .invert           (invert_r),
    .head_item        (q_head_item),
    .q_status         (q_status),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_pixel_colour (out_pixel_colour),
    .out_last_pixel   (out_last_pixel)
  );

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 48;
  localparam int HOLD_CYCLES  = 400;

  typedef struct {
    logic [15:0] colour;
    logic        last;
  } pixel_t;

  // clock, reset and block ports
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [1:0]  in_command = 2'd0;
  logic [8:0]  in_address = 9'd0;
  logic [31:0] in_write_data = 32'd0;
  logic [8:0]  in_screen_row = 9'd0;
  logic [3:0]  in_tile_column = 4'd0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [15:0] out_pixel_colour;
  logic        out_last_pixel;
  logic        cfg_write_enable = 1'b0;
  logic        cfg_write_data = 1'b0;

  // mirror of the block's stores and register
  bit [3:0]  map_mirror [tmpg_pkg::MAP_SIZE];
  bit [31:0] pattern_mirror [tmpg_pkg::PATTERN_SIZE];
  bit        pattern_loaded [tmpg_pkg::PATTERN_SIZE];
  bit [15:0] palette_mirror [tmpg_pkg::PALETTE_SIZE];
  bit        palette_loaded [tmpg_pkg::PALETTE_SIZE];
  bit        invert_on = 1'b0;

  // pixels still to come out, oldest first
  pixel_t pixel_queue [$];
  pixel_t want;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int items_sent = 0;
  int renders_sent = 0;
  int pixels_checked = 0;
  int error_count = 0;
  int cycle_count = 0;
  int hold_left = 0;
  logic hold_start = 1'b0;

  tile_map_pixel_generator uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_command       (in_command),
    .in_address       (in_address),
    .in_write_data    (in_write_data),
    .in_screen_row    (in_screen_row),
    .in_tile_column   (in_tile_column),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_pixel_colour (out_pixel_colour),
    .out_last_pixel   (out_last_pixel),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // tile number under a screen row and column, zero outside the map
  function automatic int tile_at(logic [8:0] row, logic [3:0] col);
    int trow;
    trow = row / tmpg_pkg::TILE_SIDE;
    if (trow < tmpg_pkg::MAP_ROWS && col < tmpg_pkg::MAP_COLUMNS)
      return int'(map_mirror[trow * tmpg_pkg::MAP_COLUMNS + col]);
    return 0;
  endfunction

  // pattern word of one half of a tile line
  function automatic logic [31:0] line_word(int tile, int line, int half);
    if (tile >= tmpg_pkg::TILE_COUNT) return 32'd0;
    return pattern_mirror[tile * tmpg_pkg::WORDS_PER_TILE +
                          line * tmpg_pkg::WORDS_PER_LINE + half];
  endfunction

  // palette index of one pixel, leftmost nibble first
  function automatic int line_nibble(int tile, int line, int p);
    logic [31:0] word;
    word = line_word(tile, line, p / 8);
    return int'((word >> (28 - 4 * (p % 8))) & 32'hF);
  endfunction

  // expected pixels of one render
  function automatic void predict_render(logic [8:0] row, logic [3:0] col);
    int tile;
    int line;
    pixel_t px;
    tile = tile_at(row, col);
    line = row % tmpg_pkg::TILE_SIDE;
    for (int p = 0; p < tmpg_pkg::TILE_SIDE; p++) begin
      px.colour = palette_mirror[line_nibble(tile, line, p)];
      if (invert_on) px.colour = ~px.colour;
      px.last = (p == tmpg_pkg::TILE_SIDE - 1);
      pixel_queue.push_back(px);
    end
  endfunction

  // one input transaction, with random idle cycles ahead of it
  task automatic send_item(tmpg_pkg::cmd_t cmd, logic [8:0] addr, logic [31:0] data,
                           logic [8:0] row, logic [3:0] col);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_command <= cmd;
    in_address <= addr;
    in_write_data <= data;
    in_screen_row <= row;
    in_tile_column <= col;
    do @(posedge clk); while (in_full);
    items_sent++;
    case (cmd)
      tmpg_pkg::CMD_MAP_WR: if (addr < tmpg_pkg::MAP_SIZE) map_mirror[addr] = data[3:0];
      tmpg_pkg::CMD_PAT_WR: begin
        if (addr < tmpg_pkg::PATTERN_SIZE) begin
          pattern_mirror[addr] = data;
          pattern_loaded[addr] = 1'b1;
        end
      end
      tmpg_pkg::CMD_PAL_WR: begin
        if (addr < tmpg_pkg::PALETTE_SIZE) begin
          palette_mirror[addr] = data[15:0];
          palette_loaded[addr] = 1'b1;
        end
      end
      default: begin
        renders_sent++;
        predict_render(row, col);
      end
    endcase
  endtask

  // load any pattern word or colour the next render would read unwritten
  task automatic preload_line(logic [8:0] row, logic [3:0] col);
    int tile;
    int line;
    int a;
    int nib;
    tile = tile_at(row, col);
    line = row % tmpg_pkg::TILE_SIDE;
    for (int h = 0; h < tmpg_pkg::WORDS_PER_LINE; h++) begin
      a = tile * tmpg_pkg::WORDS_PER_TILE + line * tmpg_pkg::WORDS_PER_LINE + h;
      if (tile < tmpg_pkg::TILE_COUNT && !pattern_loaded[a])
        send_item(tmpg_pkg::CMD_PAT_WR, a[8:0], 32'($urandom),
                  9'($urandom_range(511)), 4'($urandom_range(15)));
    end
    for (int p = 0; p < tmpg_pkg::TILE_SIDE; p++) begin
      nib = line_nibble(tile, line, p);
      if (!palette_loaded[nib])
        send_item(tmpg_pkg::CMD_PAL_WR, nib[8:0], 32'($urandom),
                  9'($urandom_range(511)), 4'($urandom_range(15)));
    end
  endtask

  task automatic send_render(logic [8:0] row, logic [3:0] col);
    preload_line(row, col);
    send_item(tmpg_pkg::CMD_RENDER, 9'($urandom_range(511)), 32'($urandom), row, col);
  endtask

  // drop push, drain every expected pixel, then let queued writes finish
  task automatic wait_idle();
    in_push <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_invert(bit v);
    wait_idle();
    cfg_write_enable <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    invert_on = v;
  endtask

  // palette and pattern extremes, out of range palette writes
  task automatic test_store_loading();
    tx_idle_pct = 19;
    rx_idle_pct = 50;
    set_invert(1'b0);
    send_item(tmpg_pkg::CMD_PAL_WR, 9'd0, 32'hFFFF_0000, 9'd0, 4'd0);
    send_item(tmpg_pkg::CMD_PAL_WR, 9'd15, 32'h0000_FFFF, 9'd511, 4'd15);
    send_item(tmpg_pkg::CMD_PAL_WR, 9'd16, 32'h0000_1234, 9'd0, 4'd0);
    send_item(tmpg_pkg::CMD_PAL_WR, 9'd511, 32'h0000_ABCD, 9'd0, 4'd0);
    send_item(tmpg_pkg::CMD_PAT_WR, 9'd0, 32'h0123_4567, 9'd0, 4'd0);
    send_item(tmpg_pkg::CMD_PAT_WR, 9'd1, 32'h89AB_CDEF, 9'd0, 4'd0);
    send_item(tmpg_pkg::CMD_PAT_WR, 9'd510, 32'h0000_0000, 9'd0, 4'd0);
    send_item(tmpg_pkg::CMD_PAT_WR, 9'd511, 32'hFFFF_FFFF, 9'd0, 4'd0);
    send_render(9'd0, 4'd0);
    wait_idle();
  endtask

  // map corners, out of range map writes, renders off the map
  task automatic test_map_edges();
    send_item(tmpg_pkg::CMD_MAP_WR, 9'(tmpg_pkg::MAP_SIZE - 1), 32'hFFFF_FFFF, 9'd0, 4'd0);
    send_render(9'd319, 4'd14);
    send_item(tmpg_pkg::CMD_MAP_WR, 9'd0, 32'h0000_000F, 9'd0, 4'd0);
    send_render(9'd15, 4'd0);
    send_item(tmpg_pkg::CMD_MAP_WR, 9'd0, 32'h0000_0000, 9'd0, 4'd0);
    send_item(tmpg_pkg::CMD_MAP_WR, 9'(tmpg_pkg::MAP_SIZE), 32'h0000_000F, 9'd0, 4'd0);
    send_item(tmpg_pkg::CMD_MAP_WR, 9'd511, 32'h0000_000F, 9'd0, 4'd0);
    send_render(9'd320, 4'd0);
    send_render(9'd511, 4'd14);
    send_render(9'd0, 4'd15);
    send_render(9'd0, 4'd0);
    wait_idle();
  endtask

  task automatic test_invert();
    set_invert(1'b1);
    send_render(9'd0, 4'd0);
    send_render(9'd319, 4'd14);
    wait_idle();
  endtask

  // random mix of writes and renders
  task automatic test_random(int count, int tx_pct, int rx_pct, bit inv);
    int r;
    logic [8:0] a;
    logic [8:0] row;
    logic [3:0] col;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    set_invert(inv);
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 15) begin
        a = ($urandom_range(7) == 0) ? 9'($urandom_range(511, tmpg_pkg::MAP_SIZE)) :
                                       9'($urandom_range(tmpg_pkg::MAP_SIZE - 1));
        send_item(tmpg_pkg::CMD_MAP_WR, a, 32'($urandom), 9'($urandom_range(511)),
                  4'($urandom_range(15)));
      end else if (r < 30) begin
        send_item(tmpg_pkg::CMD_PAT_WR, 9'($urandom_range(511)), 32'($urandom),
                  9'($urandom_range(511)), 4'($urandom_range(15)));
      end else if (r < 40) begin
        a = ($urandom_range(9) == 0) ? 9'($urandom_range(511, tmpg_pkg::PALETTE_SIZE)) :
                                       9'($urandom_range(15));
        send_item(tmpg_pkg::CMD_PAL_WR, a, 32'($urandom), 9'($urandom_range(511)),
                  4'($urandom_range(15)));
      end else begin
        row = ($urandom_range(6) == 0) ? 9'($urandom_range(511, 320)) :
                                         9'($urandom_range(319));
        col = ($urandom_range(9) == 0) ? 4'd15 : 4'($urandom_range(14));
        send_render(row, col);
      end
    end
    wait_idle();
  endtask

  // receiver holds off while renders keep coming, so the input stalls
  task automatic test_back_pressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    repeat (12) send_render(9'($urandom_range(319)), 4'($urandom_range(14)));
    wait_idle();
  endtask

  // hold-off counter for the receiver
  always @(posedge clk) begin
    if (hold_start) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // pixel check on every out transaction, random pop for the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (pixel_queue.size() == 0) begin
          $error("out transaction with no pixel expected: pixel_colour %h last_pixel %b",
                 out_pixel_colour, out_last_pixel);
          error_count++;
        end else begin
          want = pixel_queue.pop_front();
          pixels_checked++;
          if (out_pixel_colour !== want.colour) begin
            $error("pixel_colour mismatch: expected %h, got %h", want.colour, out_pixel_colour);
            error_count++;
          end
          if (out_last_pixel !== want.last) begin
            $error("last_pixel mismatch: expected %b, got %b", want.last, out_last_pixel);
            error_count++;
          end
        end
      end
      out_pop <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_store_loading();
    test_map_edges();
    test_invert();
    test_random(95, 19, 50, 1'b1);
    test_random(95, 50, 19, 1'b0);
    test_random(95, 0, 0, 1'($urandom_range(1)));
    test_back_pressure();
    wait_idle();
    $display("covered %0d input transactions, %0d of them renders, and %0d pixels checked",
             items_sent, renders_sent, pixels_checked);
    $display("with inverting on and off, idle on both sides and a %0d cycle receiver hold-off",
             HOLD_CYCLES);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
